@@ design/pbws_pkg.sv @@
`timescale 1ns / 1ps
package pbws_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam int OFF_W      = 32;
   localparam int LEN_W      = 32;
   localparam int CNT_W      = 17;
   localparam int AB_W       = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CAP_W      = 33;
   localparam int DIV_CNT_W  = $clog2(OFF_W);

   localparam logic [CNT_W-1:0] PAGE_SIZE_RST   = CNT_W'(64);
   localparam logic [CNT_W-1:0] PAGE_COUNT_RST  = CNT_W'(512);
   localparam logic [CNT_W-1:0] BUFFER_SIZE_RST = CNT_W'(64);
   localparam logic [AB_W-1:0]  ADDR_BYTES_RST  = AB_W'(2);
   localparam logic [CNT_W-1:0] CNT_MAX         = CNT_W'(65536);
   localparam logic [CAP_W-1:0] ADDR_SPACE      = CAP_W'(1) << ADDR_WIDTH;

   typedef enum logic [1:0] {
      KIND_CHUNK  = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_PROTO  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SIZE   = 2'd0,
      CSR_PAGE_COUNT  = 2'd1,
      CSR_BUFFER_SIZE = 2'd2,
      CSR_ADDR_BYTES  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      RES_CHUNK,
      RES_DONE,
      RES_DONE_ZERO,
      RES_REJECT,
      RES_PROTO
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_CHECK,
      S_ROOM,
      S_DIV,
      S_ISSUE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic    load;
      logic    mul;
      logic    start;
      logic    final_ack;
      logic    abort;
      logic    advance;
      logic    div_init;
      logic    div_step;
      logic    issue;
      logic    emit;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic opcode;
      logic busy;
      logic len_zero;
      logic final_chunk;
      logic ack_match;
      logic buffer_mode;
      logic oob;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] lo);
      logic [CNT_W-1:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > CNT_MAX) r = CNT_MAX;
      return r;
   endfunction

endpackage

@@ design/pbws_req_if.sv @@
`timescale 1ns / 1ps
interface pbws_req_if;
   import pbws_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [OFF_W-1:0] request_offset;
   logic [LEN_W-1:0] request_length;
   logic [CNT_W-1:0] ack_count;

   modport source(output valid, output opcode, output request_offset,
                  output request_length, output ack_count, input ready);
   modport sink(input valid, input opcode, input request_offset,
                input request_length, input ack_count, output ready);
endinterface

@@ design/pbws_rsp_if.sv @@
`timescale 1ns / 1ps
interface pbws_rsp_if;
   import pbws_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic [OFF_W-1:0] chunk_offset;
   logic [CNT_W-1:0] chunk_length;
   logic [LEN_W-1:0] total_written;

   modport source(output valid, output kind, output chunk_offset,
                  output chunk_length, output total_written, input ready);
   modport sink(input valid, input kind, input chunk_offset,
                input chunk_length, input total_written, output ready);
endinterface

@@ design/pbws_ctrl.sv @@
`timescale 1ns / 1ps
module pbws_ctrl
   import pbws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   res_type   res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= RES_DONE;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.res   = res_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_OUT;
            if (!status.opcode) begin
               if (status.busy) begin
                  res_in = RES_PROTO;
               end else if (status.len_zero) begin
                  res_in = RES_DONE_ZERO;
               end else begin
                  state_in = S_MUL;
               end
            end else if (!status.busy) begin
               res_in = RES_PROTO;
            end else if (status.final_chunk) begin
               cmd.final_ack = 1'b1;
               res_in        = RES_DONE;
            end else if (!status.ack_match) begin
               cmd.abort = 1'b1;
               res_in    = RES_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_ROOM;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.oob) begin
               res_in   = RES_REJECT;
               state_in = S_OUT;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_ROOM;
            end
         end
         S_ROOM: begin
            if (status.buffer_mode) begin
               state_in = S_ISSUE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            res_in    = RES_CHUNK;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/pbws_dp.sv @@
`timescale 1ns / 1ps
module pbws_dp
   import pbws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   input  logic                 in_opcode,
   input  logic [OFF_W-1:0]     in_offset,
   input  logic [LEN_W-1:0]     in_length,
   input  logic [CNT_W-1:0]     in_ack,
   input  cmd_type              cmd,
   output status_type           status,
   pbws_rsp_if.source           rsp
);

   logic [CNT_W-1:0]     page_size_ff, page_count_ff, buffer_size_ff;
   logic [AB_W-1:0]      addr_bytes_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   logic                 op_ff;
   logic [OFF_W-1:0]     off_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [CNT_W-1:0]     ack_ff;
   logic [CAP_W-1:0]     prod_ff;
   logic [OFF_W-1:0]     next_addr_ff;
   logic [LEN_W-1:0]     bytes_left_ff;
   logic [LEN_W-1:0]     bytes_done_ff;
   logic [CNT_W-1:0]     pending_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [OFF_W-1:0]     div_addr_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [1:0]           kind_ff;
   logic [OFF_W-1:0]     chunk_off_ff;
   logic [CNT_W-1:0]     chunk_len_ff;
   logic [LEN_W-1:0]     total_ff;

   logic [CNT_W-1:0] ab_ext, room, chunk, sub_rem;
   logic [CNT_W:0]   rem_sh;
   logic [CAP_W-1:0] cap, end_addr;
   logic [LEN_W:0]   done_sum;
   logic             buffer_mode;
   kind_type         out_kind;
   logic [OFF_W-1:0] out_off;
   logic [CNT_W-1:0] out_len;
   logic [LEN_W-1:0] out_total;

   assign buffer_mode = (page_count_ff == CNT_W'(1));
   assign ab_ext      = CNT_W'(addr_bytes_ff);
   assign cap         = (prod_ff < ADDR_SPACE) ? prod_ff : ADDR_SPACE;
   assign end_addr    = CAP_W'(off_ff) + CAP_W'(len_ff);
   assign rem_sh      = {rem_ff, div_addr_ff[OFF_W-1]};
   assign sub_rem     = CNT_W'(rem_sh - {1'b0, page_size_ff});
   assign done_sum    = {1'b0, bytes_done_ff} + (LEN_W + 1)'(ack_ff);

   always_comb begin
      if (buffer_mode) begin
         room = (buffer_size_ff > ab_ext) ? buffer_size_ff - ab_ext : CNT_W'(1);
      end else begin
         room = page_size_ff - rem_ff;
      end
      chunk = (bytes_left_ff < LEN_W'(room)) ? bytes_left_ff[CNT_W-1:0] : room;
   end

   always_comb begin
      status.opcode      = op_ff;
      status.busy        = busy_ff;
      status.len_zero    = (len_ff == '0);
      status.final_chunk = (LEN_W'(pending_ff) >= bytes_left_ff);
      status.ack_match   = (ack_ff == pending_ff);
      status.buffer_mode = buffer_mode;
      status.oob         = (end_addr > cap);
      status.div_last    = (div_cnt_ff == DIV_CNT_W'(OFF_W - 1));
      status.out_free    = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      out_kind  = KIND_PROTO;
      out_off   = '0;
      out_len   = '0;
      out_total = '0;
      case (cmd.res)
         RES_CHUNK: begin
            out_kind  = KIND_CHUNK;
            out_off   = next_addr_ff;
            out_len   = pending_ff;
            out_total = bytes_done_ff;
         end
         RES_DONE: begin
            out_kind  = KIND_DONE;
            out_total = bytes_done_ff;
         end
         RES_DONE_ZERO: out_kind = KIND_DONE;
         RES_REJECT:    out_kind = KIND_REJECT;
         RES_PROTO:     out_kind = KIND_PROTO;
         default:       out_kind = KIND_PROTO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff   <= PAGE_SIZE_RST;
         page_count_ff  <= PAGE_COUNT_RST;
         buffer_size_ff <= BUFFER_SIZE_RST;
         addr_bytes_ff  <= ADDR_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAGE_SIZE:   page_size_ff   <= clamp_cnt(csr_wdata, CNT_W'(1));
            CSR_PAGE_COUNT:  page_count_ff  <= clamp_cnt(csr_wdata, CNT_W'(1));
            CSR_BUFFER_SIZE: buffer_size_ff <= clamp_cnt(csr_wdata, CNT_W'(2));
            CSR_ADDR_BYTES: begin
               if (csr_wdata[AB_W-1:0] == '0) addr_bytes_ff <= AB_W'(1);
               else if (csr_wdata[AB_W-1:0] > AB_W'(4)) addr_bytes_ff <= AB_W'(4);
               else addr_bytes_ff <= csr_wdata[AB_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) busy_ff <= 1'b1;
         else if (cmd.final_ack || cmd.abort) busy_ff <= 1'b0;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_opcode;
         off_ff <= in_offset;
         len_ff <= in_length;
         ack_ff <= in_ack;
      end
      if (cmd.mul) prod_ff <= CAP_W'(page_size_ff) * CAP_W'(page_count_ff);
      if (cmd.start) begin
         next_addr_ff  <= off_ff;
         bytes_left_ff <= len_ff;
         bytes_done_ff <= '0;
      end
      if (cmd.final_ack) begin
         if (!buffer_mode || (ack_ff == pending_ff)) begin
            bytes_done_ff <= done_sum[LEN_W] ? '1 : done_sum[LEN_W-1:0];
         end
         bytes_left_ff <= '0;
         next_addr_ff  <= next_addr_ff + OFF_W'(pending_ff);
      end
      if (cmd.abort) bytes_left_ff <= '0;
      if (cmd.advance) begin
         bytes_done_ff <= done_sum[LEN_W-1:0];
         bytes_left_ff <= bytes_left_ff - LEN_W'(pending_ff);
         next_addr_ff  <= next_addr_ff + OFF_W'(pending_ff);
      end
      if (cmd.div_init) begin
         rem_ff      <= '0;
         div_addr_ff <= next_addr_ff;
         div_cnt_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff      <= (rem_sh >= {1'b0, page_size_ff}) ? sub_rem : rem_sh[CNT_W-1:0];
         div_addr_ff <= {div_addr_ff[OFF_W-2:0], 1'b0};
         div_cnt_ff  <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.issue) pending_ff <= chunk;
      if (cmd.emit) begin
         kind_ff      <= out_kind;
         chunk_off_ff <= out_off;
         chunk_len_ff <= out_len;
         total_ff     <= out_total;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.chunk_offset  = chunk_off_ff;
   assign rsp.chunk_length  = chunk_len_ff;
   assign rsp.total_written = total_ff;

endmodule

@@ design/page_boundary_write_splitter_unit.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// req      in   valid/ready        opcode, request_offset, request_length, ack_count
// rsp      out  valid/ready        kind, chunk_offset, chunk_length, total_written
// csr      in   csr_we             csr_index, csr_wdata
//
// One transaction at a time. A chunk in page mode, whether after a start or after an
// acknowledgement, passes through the 32-step bit-serial offset-modulo-page divider;
// buffer mode and immediate answers skip the divider.
// A finished result waits in the rsp register while the next req is taken;
// the block stalls only when a second result is ready before the first is taken.
// Synchronous reset restores register defaults and returns to idle.
module page_boundary_write_splitter_unit
   import pbws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pbws_req_if.sink             req,
   pbws_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       ready;

   assign req.ready = ready;

   pbws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbws_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_opcode (req.opcode),
      .in_offset (req.request_offset),
      .in_length (req.request_length),
      .in_ack    (req.ack_count),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp)
   );

endmodule
